/* sv/deque_with_positional_insert_assert.svh */
// ----------------------------------------------------------------------------
// Deque assertion macros
// Shorthands for the concurrent checks at the end of the deque top level.
// They expect signals named clk and rst_n in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef DEQUE_WITH_POSITIONAL_INSERT_ASSERT_SVH
`define DEQUE_WITH_POSITIONAL_INSERT_ASSERT_SVH

// Condition must hold at every clock edge outside reset
`define DEQ_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication
`define DEQ_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/deq_pkg.sv */
// ----------------------------------------------------------------------------
// Deque package
// Command and result item types, operation codes and status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package deq_pkg;

    // Operation codes
    localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [2:0] KIND_POP_BACK   = 3'd3;
    localparam logic [2:0] KIND_INSERT     = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_BADPOS = 2'd3;

    // Width of the position and count fields
    localparam int POS_BITS = 5;

    typedef struct packed {
        logic [2:0]          kind;
        logic signed [31:0]  value;
        logic [POS_BITS-1:0] position;
    } deq_cmd_t;

    typedef struct packed {
        logic [1:0]          status;
        logic signed [31:0]  front_value;
        logic signed [31:0]  back_value;
        logic [POS_BITS-1:0] entry_count;
    } deq_result_t;

endpackage

/* sv/deque_with_positional_insert.sv */
// ----------------------------------------------------------------------------
// Deque with positional insert
// Bounded double-ended queue of signed words held in a circular RAM.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result shows on
// result for exactly one cycle with done high, and must be taken then. Push,
// pop and failed operations go from accept to the next possible accept
// through these steps: update the RAM and pointers, read the front and back
// words, register the result. An insert that moves entries first shifts the
// entries from the insert position on up one slot, then writes the new word:
// every moved entry is one RAM read and one RAM write through the single write
// port. Words are stored in WORD_BITS bits and reported sign-extended to 32
// bits. Entry storage needs no clearing after reset.
`timescale 1ns / 1ps

module deque_with_positional_insert #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  deq_pkg::deq_cmd_t   cmd,
    output logic                busy,
    output logic                done,
    output deq_pkg::deq_result_t result
);

    import deq_pkg::*;

    `include "deque_with_positional_insert_assert.svh"

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_BITS) ? CW : POS_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INSERT,
        S_READ,
        S_REPLY
    } state_t;

    state_t               state_reg, state_next;
    logic [AW-1:0]        front_reg, front_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic [WORD_BITS-1:0] word_reg, word_next;
    logic [1:0]           status_reg, status_next;
    deq_result_t          result_reg, result_next;
    logic                 done_reg, done_next;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [AW-1:0]        mem_raddr_a;
    logic [AW-1:0]        mem_raddr_b;
    logic [WORD_BITS-1:0] mem_rdata_a;
    logic [WORD_BITS-1:0] mem_rdata_b;

    logic [WORD_BITS-1:0] in_word;
    logic [PW-1:0]        in_pos;
    logic                 is_full;
    logic                 is_empty;
    logic [AW-1:0]        front_dec;

    // Physical slot of a logical position
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] front,
                                              input logic [CW-1:0] p);
        logic [CW:0] s;
        s = (CW+1)'(front) + (CW+1)'(p);
        if (s >= (CW+1)'(DEPTH))
        begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // Stored word to 32-bit signed output
    function automatic logic [31:0] word_out(input logic [WORD_BITS-1:0] w);
        logic [63:0] w64;
        w64 = 64'($signed(w));
        return w64[31:0];
    endfunction

    deq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (WORD_BITS)
    ) u_ram (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    // Input decode
    assign in_word   = WORD_BITS'($signed(cmd.value));
    assign in_pos    = PW'(cmd.position);
    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - AW'(1);

    // Sequencer and RAM control
    always_comb
    begin
        state_next  = state_reg;
        front_next  = front_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        word_next   = word_reg;
        status_next = status_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = front_reg;
        mem_wdata   = word_reg;
        mem_raddr_a = front_reg;
        mem_raddr_b = is_empty ? front_reg : slot_of(front_reg, count_reg - CW'(1));

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next  = S_READ;
                    status_next = ST_OK;
                    unique case (cmd.kind)
                        KIND_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = front_dec;
                                mem_wdata  = in_word;
                                front_next = front_dec;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        KIND_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = slot_of(front_reg, count_reg);
                                mem_wdata  = in_word;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        KIND_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                front_next = slot_of(front_reg, CW'(1));
                                count_next = count_reg - CW'(1);
                            end
                        end
                        KIND_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        KIND_INSERT:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else if (in_pos > PW'(count_reg))
                            begin
                                status_next = ST_BADPOS;
                            end
                            else if (in_pos == PW'(count_reg))
                            begin
                                // insert at the end is an append
                                mem_we     = 1'b1;
                                mem_waddr  = slot_of(front_reg, count_reg);
                                mem_wdata  = in_word;
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                pos_next   = CW'(in_pos);
                                word_next  = in_word;
                                state_next = S_SHIFT_RD;
                            end
                        end
                        default:
                        begin
                            // unused codes: no operation
                        end
                    endcase
                end
            end
            S_SHIFT_RD:
            begin
                // fetch the entry that moves into slot idx
                mem_raddr_a = slot_of(front_reg, idx_reg - CW'(1));
                state_next  = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = slot_of(front_reg, idx_reg);
                mem_wdata = mem_rdata_a;
                idx_next  = idx_reg - CW'(1);
                if (idx_reg - CW'(1) == pos_reg)
                begin
                    state_next = S_INSERT;
                end
                else
                begin
                    state_next = S_SHIFT_RD;
                end
            end
            S_INSERT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = slot_of(front_reg, pos_reg);
                mem_wdata  = word_reg;
                count_next = count_reg + CW'(1);
                state_next = S_READ;
            end
            S_READ:
            begin
                // read addresses for front and back are the defaults
                state_next = S_REPLY;
            end
            S_REPLY:
            begin
                result_next.status      = status_reg;
                result_next.entry_count = POS_BITS'(count_reg);
                if (is_empty)
                begin
                    result_next.front_value = '0;
                    result_next.back_value  = '0;
                end
                else
                begin
                    result_next.front_value = word_out(mem_rdata_a);
                    result_next.back_value  = word_out(mem_rdata_b);
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            front_reg  <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            front_reg  <= front_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        word_reg   <= word_next;
        status_reg <= status_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // Checks
    `DEQ_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(DEPTH), "entry count above depth")
    `DEQ_ASSERT_NEXT(a_done_pulse, done_reg, !done_reg, "result strobe longer than one cycle")
    `DEQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `DEQ_ASSERT_IMPLIES(a_empty_zero, done_reg && count_reg == '0,
        result_reg.front_value == '0 && result_reg.back_value == '0,
        "empty queue reported nonzero words")

endmodule

/* sv/deq_ram.sv */
// ----------------------------------------------------------------------------
// Deque entry RAM
// Synchronous RAM, one write port and two read ports, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read ports, registered read data
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// Deque with positional insert: testbench
// Drives push, pop and insert items from a pending queue and keeps its own
// deque model to work out each result. Every strobed result is checked
// against the oldest predicted result. Stimulus is a short directed opening,
// then random fill, drain and mixed bursts with some malformed items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import deq_pkg::*;

    localparam int DEPTH      = 16;
    localparam int N_ITEMS    = 1200;
    localparam int MAX_SHOWN  = 10;
    localparam int DRAIN_WAIT = 500;
    localparam int TAIL_WAIT  = 40;

    // One pending item; wait_drain holds it back until all results are in
    typedef struct {
        deq_cmd_t c;
        bit       wait_drain;
    } stim_t;

    logic        clk;
    logic        rst_n   = 1'b0;
    logic        start   = 1'b0;
    deq_cmd_t    cmd_bus = '0;
    logic        busy;
    logic        done;
    deq_result_t result;

    stim_t       pending_cmds[$];
    deq_result_t expected_results[$];

    // Deque model state
    logic signed [31:0] dq_words [DEPTH];
    logic [3:0]         dq_head = '0;
    logic [4:0]         dq_fill = '0;

    // Count tracker used while building stimulus
    int  gen_fill   = 0;
    bit  pause_next = 1'b0;

    logic cmd_taken = 1'b0;
    int   n_accepted = 0;
    int   n_checked  = 0;
    int   n_fail     = 0;
    int   n_full     = 0;
    int   n_empty    = 0;
    int   n_badpos   = 0;
    int   n_inserted = 0;

    deque_with_positional_insert dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd_bus),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Reset held low from time zero, released on a falling edge
    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Run limit
    initial
    begin
        #2000000;
        $display("testbench: done, errors");
        $finish;
    end

    // Physical slot of a logical position
    function automatic logic [3:0] slot_of(input logic [4:0] p);
        return dq_head + p[3:0];
    endfunction

    // Apply one item to the model and return the result it should produce
    function automatic deq_result_t model_step(input deq_cmd_t c);
        deq_result_t r;
        logic [4:0]  i;
        r.status = ST_OK;
        case (c.kind)
            KIND_PUSH_FRONT:
            begin
                if (dq_fill == DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    dq_head           = dq_head - 4'd1;
                    dq_words[dq_head] = c.value;
                    dq_fill           = dq_fill + 5'd1;
                end
            end
            KIND_PUSH_BACK:
            begin
                if (dq_fill == DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    dq_words[slot_of(dq_fill)] = c.value;
                    dq_fill                    = dq_fill + 5'd1;
                end
            end
            KIND_POP_FRONT:
            begin
                if (dq_fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    dq_head = dq_head + 4'd1;
                    dq_fill = dq_fill - 5'd1;
                end
            end
            KIND_POP_BACK:
            begin
                if (dq_fill == 0)
                    r.status = ST_EMPTY;
                else
                    dq_fill = dq_fill - 5'd1;
            end
            KIND_INSERT:
            begin
                // full check takes priority over the position check
                if (dq_fill == DEPTH)
                    r.status = ST_FULL;
                else if (c.position > dq_fill)
                    r.status = ST_BADPOS;
                else
                begin
                    for (i = dq_fill; i > c.position; i--)
                        dq_words[slot_of(i)] = dq_words[slot_of(i - 5'd1)];
                    dq_words[slot_of(c.position)] = c.value;
                    dq_fill = dq_fill + 5'd1;
                end
            end
            default: ;
        endcase
        if (dq_fill == 0)
        begin
            r.front_value = '0;
            r.back_value  = '0;
        end
        else
        begin
            r.front_value = dq_words[dq_head];
            r.back_value  = dq_words[slot_of(dq_fill - 5'd1)];
        end
        r.entry_count = dq_fill;
        return r;
    endfunction

    // Queue one item and track the entry count it leads to
    task automatic add_cmd(input logic [2:0] kind, input logic [31:0] value,
                           input logic [4:0] position);
        stim_t s;
        s.c.kind     = kind;
        s.c.value    = value;
        s.c.position = position;
        s.wait_drain = pause_next;
        pause_next   = 1'b0;
        pending_cmds.push_back(s);
        case (kind)
            KIND_PUSH_FRONT, KIND_PUSH_BACK:
                if (gen_fill < DEPTH) gen_fill++;
            KIND_POP_FRONT, KIND_POP_BACK:
                if (gen_fill > 0) gen_fill--;
            KIND_INSERT:
                if (gen_fill < DEPTH && position <= gen_fill) gen_fill++;
            default: ;
        endcase
    endtask

    // Mostly random words, with the extremes now and then
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 19))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // One random operation; push_pct and ins_pct bias toward adding entries
    task automatic gen_op(input int push_pct, input int ins_pct);
        int          roll;
        logic [4:0]  pos;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            add_cmd($urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT, rand_word(),
                    5'($urandom_range(0, 31)));
        else if (roll < push_pct + ins_pct)
        begin
            if ($urandom_range(0, 9) != 0)
                pos = 5'($urandom_range(0, gen_fill));
            else
                pos = 5'($urandom_range(0, 31));
            add_cmd(KIND_INSERT, rand_word(), pos);
        end
        else
            add_cmd($urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT, rand_word(),
                    5'($urandom_range(0, 31)));
    endtask

    // Stimulus and end of run
    initial
    begin
        int mode;
        int burst;
        int next_pause;
        int waited;
        int leftover;

        // Directed opening: empty errors, extremes, append, middle insert
        add_cmd(KIND_POP_FRONT, 32'h0, 5'd0);
        add_cmd(KIND_POP_BACK, 32'h0, 5'd0);
        add_cmd(KIND_INSERT, 32'h1234_5678, 5'd1);
        add_cmd(KIND_INSERT, 32'h8000_0000, 5'd0);
        add_cmd(KIND_PUSH_FRONT, 32'h7fff_ffff, 5'd31);
        add_cmd(KIND_PUSH_BACK, 32'hffff_ffff, 5'd16);
        add_cmd(KIND_INSERT, 32'h5555_5555, 5'd3);
        add_cmd(KIND_INSERT, 32'haaaa_aaaa, 5'd1);
        add_cmd(KIND_INSERT, 32'h0000_0001, 5'd31);
        add_cmd(KIND_INSERT, 32'h0000_0002, 5'd6);
        add_cmd(KIND_INSERT, 32'h0000_0003, 5'd5);
        add_cmd(3'd5, 32'hdead_beef, 5'd0);
        add_cmd(3'd6, 32'h0, 5'd17);
        add_cmd(3'd7, 32'hffff_ffff, 5'd31);
        add_cmd(KIND_POP_BACK, 32'h0, 5'd0);
        add_cmd(KIND_POP_FRONT, 32'h0, 5'd0);
        add_cmd(KIND_POP_FRONT, 32'h0, 5'd0);
        add_cmd(KIND_POP_BACK, 32'h0, 5'd0);
        add_cmd(KIND_POP_BACK, 32'h0, 5'd0);
        add_cmd(KIND_POP_FRONT, 32'h0, 5'd0);
        add_cmd(KIND_POP_FRONT, 32'h0, 5'd0);

        // Random bursts: fill to full, drain to empty, mixed, and noise
        next_pause = 400;
        pause_next = 1'b1;
        while (pending_cmds.size() < N_ITEMS)
        begin
            if (pending_cmds.size() >= next_pause)
            begin
                pause_next = 1'b1;
                next_pause += 400;
            end
            mode  = $urandom_range(0, 9);
            burst = $urandom_range(8, 40);
            repeat (burst)
            begin
                if (mode < 3)
                    gen_op(45, 35);
                else if (mode < 6)
                    gen_op(10, 10);
                else if (mode < 9)
                    gen_op(25, 25);
                else if ($urandom_range(0, 1))
                    add_cmd(3'($urandom_range(5, 7)), $urandom, 5'($urandom_range(0, 31)));
                else
                    add_cmd(KIND_INSERT, $urandom, 5'($urandom_range(0, 31)));
            end
        end

        // Wait for the last item to go in, then for its result
        while (pending_cmds.size() != 0 || start)
            @(posedge clk);
        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_WAIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_WAIT) @(posedge clk);

        leftover = expected_results.size();
        if (leftover != 0)
            $display("testbench: %0d expected results never arrived", leftover);
        $display("testbench: %0d items sent, %0d results checked, %0d mismatches",
                 n_accepted, n_checked, n_fail);
        $display("testbench: full %0d, empty %0d, bad position %0d, inserts applied %0d",
                 n_full, n_empty, n_badpos, n_inserted);
        if (n_fail == 0 && leftover == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // Driver: issues the next pending item on the falling edge
    always @(negedge clk)
    begin
        stim_t nxt;
        logic  go;
        if (rst_n && !(start && !cmd_taken))
        begin
            go = 1'b0;
            if (pending_cmds.size() != 0)
            begin
                if (pending_cmds[0].wait_drain && expected_results.size() != 0)
                    go = 1'b0;
                else if (!(n_accepted >= 500 && n_accepted < 750)
                         && $urandom_range(0, 99) < 27)
                    go = 1'b0;
                else
                    go = 1'b1;
            end
            if (go)
            begin
                nxt = pending_cmds.pop_front();
                cmd_bus <= nxt.c;
            end
            start <= go;
        end
    end

    // Monitor: predicts on accept, checks each strobed result
    always @(posedge clk)
    begin
        deq_result_t want;
        if (rst_n)
        begin
            cmd_taken <= start && !busy;
            if (start && !busy)
            begin
                // applied inserts are counted against the state before the step
                if (cmd_bus.kind == KIND_INSERT && dq_fill < DEPTH
                    && cmd_bus.position <= dq_fill)
                    n_inserted++;
                expected_results.push_back(model_step(cmd_bus));
                n_accepted++;
            end
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    n_fail++;
                    if (n_fail <= MAX_SHOWN)
                        $display("testbench: result with none expected: %p", result);
                end
                else
                begin
                    want = expected_results.pop_front();
                    n_checked++;
                    if (want.status == ST_FULL) n_full++;
                    if (want.status == ST_EMPTY) n_empty++;
                    if (want.status == ST_BADPOS) n_badpos++;
                    if (result.status !== want.status
                        || result.front_value !== want.front_value
                        || result.back_value !== want.back_value
                        || result.entry_count !== want.entry_count)
                    begin
                        n_fail++;
                        if (n_fail <= MAX_SHOWN)
                            $display({"testbench: result %0d mismatch: status %0d/%0d ",
                                      "front %0d/%0d back %0d/%0d count %0d/%0d ",
                                      "(expected/actual)"},
                                     n_checked, want.status, result.status,
                                     want.front_value, result.front_value,
                                     want.back_value, result.back_value,
                                     want.entry_count, result.entry_count);
                    end
                end
            end
        end
    end

endmodule
